// ===== rtl/fpr_pkg.sv =====
// Package: shared types, constants and CRC32C helper for the flow reassembler
package fpr_pkg;
  localparam int unsigned NFLOWS = 8;
  localparam int unsigned FLOW_IDX_W = (NFLOWS > 1) ? $clog2(NFLOWS) : 1;
  localparam int unsigned FLOW_CNT_W = $clog2(NFLOWS + 1);
  localparam int unsigned FRAG_BYTES = 16;
  localparam int unsigned MAX_FRAGS = 65535;
  localparam int unsigned KEY_W = 50;
  localparam int unsigned TOT_W = 21;
  localparam int unsigned RES_W = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [31:0] CRC_POLY = 32'h82f63b78;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_LIMIT = 1'b0,
    CFG_BYTE_BUDGET = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_DECL = 2'd0,
    REQ_DATA = 2'd1,
    REQ_ABORT = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_COMMIT = 4'd1, ST_BAD_ID = 4'd2, ST_BAD_DECL = 4'd3,
    ST_DUP = 4'd4, ST_NO_SLOT = 4'd5, ST_NO_BYTES = 4'd6, ST_BAD_FRAG = 4'd7,
    ST_NO_FLOW = 4'd8, ST_ORDER = 4'd9, ST_TAIL = 4'd10, ST_LEN = 4'd11,
    ST_CRC = 4'd12
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [KEY_W-1:0] key;
    logic [15:0] next_seq;
    logic [TOT_W-1:0] remaining;
    logic [15:0] frag_count;
    logic [31:0] expected_crc;
    logic [31:0] running_crc;
    logic [TOT_W-1:0] decl_bytes;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic        lookup;
    logic [KEY_W-1:0] key;
    logic        wr;
    logic [FLOW_IDX_W-1:0] wr_idx;
    entry_t      wr_entry;
  } cell_cmd_t;

  // Match result rippled along the row
  typedef struct packed {
    logic        hit;
    logic [FLOW_IDX_W-1:0] hit_idx;
    entry_t      hit_entry;
    logic        free;
    logic [FLOW_IDX_W-1:0] free_idx;
    logic [FLOW_CNT_W-1:0] open;
  } chain_t;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] source;
    logic [15:0] destination;
    logic [15:0] tag;
    logic [1:0]  subflow;
    logic [15:0] seq_or_count;
    logic        tail;
    logic [4:0]  frag_len;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [63:0] payload_bits;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] payload_lo;
    logic [63:0] payload_hi;
    logic [4:0]  payload_bytes;
    logic        payload_last;
  } rsp_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction
endpackage

// ===== rtl/fpr_if.sv =====
// Interface: valid/ready channel carrying one request or result
interface fpr_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fpr_cell.sv =====
// Flow table cell: one entry, key compare and chained match/free search
module fpr_cell
  import fpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [FLOW_IDX_W-1:0] idx_i,
  input  cell_cmd_t             cmd_i,
  input  chain_t                chain_i,
  output chain_t                chain_o
);
  entry_t entry_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.wr && cmd_i.wr_idx == idx_i) begin
      valid_q <= cmd_i.wr_entry.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && cmd_i.wr_idx == idx_i) begin
      entry_q <= cmd_i.wr_entry;
    end
  end

  always_comb begin
    chain_o = chain_i;
    if (valid_q) begin
      chain_o.open = chain_i.open + FLOW_CNT_W'(1);
      if (!chain_i.hit && entry_q.key == cmd_i.key) begin
        chain_o.hit = 1'b1;
        chain_o.hit_idx = idx_i;
        chain_o.hit_entry = entry_q;
        chain_o.hit_entry.valid = 1'b1;
      end
    end else if (!chain_i.free) begin
      chain_o.free = 1'b1;
      chain_o.free_idx = idx_i;
    end
  end
endmodule

// ===== rtl/fpr_ctrl.sv =====
// Request controller: checks, CRC update, table writes and result register
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_rsp_o,
  output cell_cmd_t   cmd_o,
  input  chain_t      chain_i
);
  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e      state_q;
  req_t        req_q;
  logic [3:0]  flow_limit_q;
  logic [RES_W-1:0] budget_q, reserved_q, reserved_d;
  logic        out_valid_q;
  rsp_t        rsp_q, rsp_d;
  logic        wr_d;
  entry_t      wr_entry_d;
  logic [FLOW_IDX_W-1:0] wr_idx_d;

  logic [KEY_W-1:0] key;
  logic [63:0] total64, mlo, mhi;
  logic [127:0] word;
  logic [60:0] frags;
  logic [4:0]  len, expect_len;
  logic        expect_tail;
  logic [31:0] crc;
  logic [RES_W:0] res_sum;

  assign key = {req_q.source, req_q.destination, req_q.tag, req_q.subflow};
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = rsp_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.lookup = (state_q == S_EXEC);
    cmd_o.key = key;
    cmd_o.wr = wr_d && (state_q == S_EXEC);
    cmd_o.wr_idx = wr_idx_d;
    cmd_o.wr_entry = wr_entry_d;
  end

  always_comb begin
    len = req_q.frag_len;
    word = {req_q.data_hi, req_q.data_lo};
    total64 = {3'd0, req_q.payload_bits[63:3]};
    frags = {1'b0, total64[63:4]} + {60'd0, |total64[3:0]};
    mlo = (len >= 5'd8) ? '1 : ((64'd1 << {len[2:0], 3'd0}) - 64'd1);
    mhi = (len >= 5'd16) ? '1 : (len <= 5'd8) ? 64'd0
        : ((64'd1 << {len[2:0], 3'd0}) - 64'd1);
    expect_tail = chain_i.hit_entry.next_seq == chain_i.hit_entry.frag_count;
    expect_len = (chain_i.hit_entry.remaining < TOT_W'(FRAG_BYTES))
               ? chain_i.hit_entry.remaining[4:0] : 5'(FRAG_BYTES);
    crc = chain_i.hit_entry.running_crc;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < len) begin
        crc = crc_byte(crc, word[8*b +: 8]);
      end
    end
    res_sum = {1'b0, reserved_q} + {4'd0, total64[TOT_W-1:0]};

    rsp_d = '0;
    wr_d = 1'b0;
    wr_idx_d = chain_i.hit_idx;
    wr_entry_d = chain_i.hit_entry;
    reserved_d = reserved_q;
    unique case (req_q.req_type)
      REQ_DECL: begin
        if (req_q.tag == 16'd0) rsp_d.status = ST_BAD_ID;
        else if (req_q.payload_bits == 64'd0 || req_q.payload_bits[2:0] != 3'd0
                 || req_q.data_hi != req_q.payload_bits
                 || req_q.data_lo[63:32] == 32'd0
                 || frags > 61'(MAX_FRAGS) || req_q.seq_or_count == 16'd0
                 || frags != {45'd0, req_q.seq_or_count})
          rsp_d.status = ST_BAD_DECL;
        else if (chain_i.hit) rsp_d.status = ST_DUP;
        else if (!chain_i.free || int'(chain_i.open) >= int'(flow_limit_q))
          rsp_d.status = ST_NO_SLOT;
        else if (res_sum > {1'b0, budget_q}) rsp_d.status = ST_NO_BYTES;
        else begin
          rsp_d.status = ST_OK;
          wr_d = 1'b1;
          wr_idx_d = chain_i.free_idx;
          wr_entry_d.valid = 1'b1;
          wr_entry_d.key = key;
          wr_entry_d.next_seq = 16'd1;
          wr_entry_d.remaining = total64[TOT_W-1:0];
          wr_entry_d.frag_count = req_q.seq_or_count;
          wr_entry_d.expected_crc = req_q.data_lo[31:0];
          wr_entry_d.running_crc = '1;
          wr_entry_d.decl_bytes = total64[TOT_W-1:0];
          reserved_d = res_sum[RES_W-1:0];
        end
      end
      REQ_DATA: begin
        if (req_q.seq_or_count == 16'd0) rsp_d.status = ST_BAD_FRAG;
        else if (req_q.tag == 16'd0) rsp_d.status = ST_BAD_ID;
        else if (len == 5'd0 || len > 5'(FRAG_BYTES)
                 || (!req_q.tail && len != 5'(FRAG_BYTES))
                 || (req_q.data_lo & ~mlo) != 64'd0 || (req_q.data_hi & ~mhi) != 64'd0)
          rsp_d.status = ST_BAD_FRAG;
        else if (!chain_i.hit) rsp_d.status = ST_NO_FLOW;
        else if (req_q.seq_or_count != chain_i.hit_entry.next_seq) rsp_d.status = ST_ORDER;
        else if (req_q.tail != expect_tail) rsp_d.status = ST_TAIL;
        else if (len != expect_len) rsp_d.status = ST_LEN;
        else begin
          wr_d = 1'b1;
          wr_entry_d.running_crc = crc;
          wr_entry_d.next_seq = chain_i.hit_entry.next_seq + 16'd1;
          wr_entry_d.remaining = chain_i.hit_entry.remaining - TOT_W'(len);
          if (expect_tail) begin
            wr_entry_d.valid = 1'b0;
            reserved_d = reserved_q - RES_W'(chain_i.hit_entry.decl_bytes);
          end
          if (expect_tail && ~crc != chain_i.hit_entry.expected_crc) begin
            rsp_d.status = ST_CRC;
          end else begin
            rsp_d.status = expect_tail ? ST_COMMIT : ST_OK;
            rsp_d.payload_lo = req_q.data_lo;
            rsp_d.payload_hi = req_q.data_hi;
            rsp_d.payload_bytes = len;
            rsp_d.payload_last = expect_tail;
          end
        end
      end
      REQ_ABORT: begin
        if (chain_i.hit) begin
          rsp_d.status = ST_OK;
          wr_d = 1'b1;
          wr_entry_d.valid = 1'b0;
          reserved_d = reserved_q - RES_W'(chain_i.hit_entry.decl_bytes);
        end else begin
          rsp_d.status = ST_NO_FLOW;
        end
      end
      default: rsp_d.status = ST_BAD_FRAG;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      flow_limit_q <= 4'd8;
      budget_q <= 24'd1048576;
      reserved_q <= '0;
      req_q <= '0;
      rsp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FLOW_LIMIT) flow_limit_q <= cfg_data_i[3:0];
        else budget_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= S_EXEC;
            req_q <= in_req_i;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          out_valid_q <= 1'b1;
          reserved_q <= reserved_d;
          rsp_q <= rsp_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE && out_valid_q) else $error("exec");
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !cmd_o.wr) else $error("write outside exec");
  a_last_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.payload_last |-> rsp_q.status == ST_COMMIT)
    else $error("last without commit");
endmodule

// ===== rtl/flow_payload_reassembler_crc32c.sv =====
// Top level: per-flow payload reassembler with CRC32C check
// Usage: requests enter on req (valid/ready), one result per request leaves
// on rsp (valid/ready). Config: cfg_we_i with cfg_idx_i 0 = flow_limit,
// 1 = byte_budget, only while idle.
// Each request is registered by the accepting edge; the next cycle does the
// flow lookup along the row of NFLOWS cells, the checks, the CRC32C update
// over up to 16 bytes and the table write. The result is registered at the
// end of that cycle, so it is offered once that execute cycle is over. A new
// request is not accepted while one executes, only once back in idle.
// A stalled result holds; the next request waits until the result register
// is free or being emptied in the same cycle.
// Reset empties the flow table, clears reserved bytes and loads
// flow_limit 8 and byte_budget 1048576.
// The cell row is searched combinationally in the execute cycle; hit and
// free-slot information ripples from cell 0 upward, lowest index first.
module flow_payload_reassembler_crc32c
  import fpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpr_if.sink         req,
  fpr_if.source       rsp
);
  cell_cmd_t cmd;
  chain_t    chain [NFLOWS+1];

  assign chain[0] = '0;

  for (genvar g = 0; g < NFLOWS; g++) begin : g_cell
    fpr_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(FLOW_IDX_W'(g)),
      .cmd_i(cmd),
      .chain_i(chain[g]),
      .chain_o(chain[g+1])
    );
  end

  fpr_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_req_i(req.data),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_rsp_o(rsp.data),
    .cmd_o(cmd), .chain_i(chain[NFLOWS])
  );
endmodule

// ===== test/fpr_reassembly_checker.sv =====
// Checker: watches request and result channels, predicts each result and compares
`timescale 1ns / 1ps
module fpr_reassembly_checker
  import fpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  req_t                  req_data_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  input  rsp_t                  rsp_data_i,
  output int unsigned           errors_o,
  output int unsigned           awaited_o
);
  localparam int unsigned EXP_DEPTH = 16;

  typedef struct {
    bit          open;
    logic [49:0] key;
    logic [15:0] next_seq;
    logic [20:0] left;
    logic [15:0] frags;
    logic [31:0] want_crc;
    logic [31:0] crc;
    logic [20:0] bytes;
  } flow_rec_t;

  flow_rec_t   flows[NFLOWS];
  logic [23:0] reserved_bytes;
  logic [3:0]  max_flows;
  logic [23:0] budget;
  rsp_t        expected_rsp[EXP_DEPTH];
  int unsigned exp_wr, exp_rd;

  initial begin
    errors_o = 0;
    awaited_o = 0;
    exp_wr = 0;
    exp_rd = 0;
    reserved_bytes = '0;
    max_flows = 4'd8;
    budget = 24'd1048576;
    foreach (flows[j]) flows[j].open = 1'b0;
  end

  function automatic logic [31:0] crc32c_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) v = (v >> 1) ^ (v[0] ? 32'h82f63b78 : 32'd0);
    return v;
  endfunction

  function automatic int find_flow(logic [49:0] k);
    for (int j = 0; j < NFLOWS; j++) if (flows[j].open && flows[j].key == k) return j;
    return -1;
  endfunction

  function automatic void close_flow(int j);
    flows[j].open = 1'b0;
    reserved_bytes = reserved_bytes - 24'(flows[j].bytes);
  endfunction

  function automatic rsp_t predict(req_t r);
    rsp_t        o;
    status_e     st;
    logic [49:0] k;
    int          i, slot, open_n;
    logic [63:0] total, nfrag, mlo, mhi;
    logic [31:0] c;
    logic [20:0] want_len;
    bit          want_tail;
    o = '0;
    k = {r.source, r.destination, r.tag, r.subflow};
    i = find_flow(k);
    st = ST_BAD_FRAG;
    case (r.req_type)
      REQ_DECL: begin
        total = r.payload_bits >> 3;
        nfrag = (total >> 4) + ((total[3:0] != 0) ? 64'd1 : 64'd0);
        if (r.tag == 0) st = ST_BAD_ID;
        else if (r.payload_bits == 0 || r.payload_bits[2:0] != 0 ||
                 r.data_hi != r.payload_bits || r.data_lo[63:32] == 0 ||
                 nfrag > MAX_FRAGS || r.seq_or_count == 0 ||
                 nfrag != {48'd0, r.seq_or_count}) st = ST_BAD_DECL;
        else if (i >= 0) st = ST_DUP;
        else begin
          slot = -1;
          open_n = 0;
          for (int j = 0; j < NFLOWS; j++) begin
            if (flows[j].open) open_n++;
            else if (slot < 0) slot = j;
          end
          if (slot < 0 || open_n >= max_flows) st = ST_NO_SLOT;
          else if ({40'd0, reserved_bytes} + total > {40'd0, budget}) st = ST_NO_BYTES;
          else begin
            st = ST_OK;
            flows[slot].open = 1'b1;
            flows[slot].key = k;
            flows[slot].next_seq = 16'd1;
            flows[slot].left = total[20:0];
            flows[slot].frags = r.seq_or_count;
            flows[slot].want_crc = r.data_lo[31:0];
            flows[slot].crc = 32'hFFFF_FFFF;
            flows[slot].bytes = total[20:0];
            reserved_bytes = reserved_bytes + 24'(total[20:0]);
          end
        end
      end
      REQ_DATA: begin
        mlo = (r.frag_len >= 8) ? '1 : ((64'd1 << (8 * r.frag_len)) - 1);
        mhi = (r.frag_len >= 16) ? '1 : (r.frag_len <= 8) ? 64'd0 :
              ((64'd1 << (8 * (r.frag_len - 8))) - 1);
        if (r.seq_or_count == 0) st = ST_BAD_FRAG;
        else if (r.tag == 0) st = ST_BAD_ID;
        else if (r.frag_len == 0 || r.frag_len > 16 ||
                 (!r.tail && r.frag_len != 16) ||
                 (r.data_lo & ~mlo) != 0 || (r.data_hi & ~mhi) != 0) st = ST_BAD_FRAG;
        else if (i < 0) st = ST_NO_FLOW;
        else if (r.seq_or_count != flows[i].next_seq) st = ST_ORDER;
        else begin
          want_tail = flows[i].next_seq == flows[i].frags;
          want_len = (flows[i].left < 16) ? flows[i].left : 21'd16;
          if (r.tail != want_tail) st = ST_TAIL;
          else if ({16'd0, r.frag_len} != want_len) st = ST_LEN;
          else begin
            c = flows[i].crc;
            for (int b = 0; b < r.frag_len; b++)
              c = crc32c_step(c, (b < 8) ? r.data_lo[8*b +: 8] : r.data_hi[8*(b-8) +: 8]);
            flows[i].crc = c;
            flows[i].next_seq = flows[i].next_seq + 16'd1;
            flows[i].left = flows[i].left - 21'(r.frag_len);
            st = ST_OK;
            if (want_tail) begin
              close_flow(i);
              st = (~c != flows[i].want_crc) ? ST_CRC : ST_COMMIT;
            end
            if (st != ST_CRC) begin
              o.payload_lo = r.data_lo;
              o.payload_hi = r.data_hi;
              o.payload_bytes = r.frag_len;
              o.payload_last = (st == ST_COMMIT);
            end
          end
        end
      end
      REQ_ABORT: begin
        if (i >= 0) begin
          close_flow(i);
          st = ST_OK;
        end else st = ST_NO_FLOW;
      end
      default: st = ST_BAD_FRAG;
    endcase
    o.status = st;
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FLOW_LIMIT) max_flows = cfg_data_i[3:0];
        else budget = cfg_data_i;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result, expected none, got %h", $time, rsp_data_i);
          errors_o++;
        end else begin
          exp_r = expected_rsp[exp_rd % EXP_DEPTH];
          exp_rd++;
          check_field("status", 64'(exp_r.status), 64'(rsp_data_i.status));
          check_field("payload_lo", exp_r.payload_lo, rsp_data_i.payload_lo);
          check_field("payload_hi", exp_r.payload_hi, rsp_data_i.payload_hi);
          check_field("payload_bytes", 64'(exp_r.payload_bytes),
                      64'(rsp_data_i.payload_bytes));
          check_field("payload_last", 64'(exp_r.payload_last),
                      64'(rsp_data_i.payload_last));
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsp[exp_wr % EXP_DEPTH] = predict(req_data_i);
        exp_wr++;
      end
      awaited_o = exp_wr - exp_rd;
    end
  end
endmodule

// ===== test/flow_payload_reassembler_crc32c_tb.sv =====
// Testbench top: drives requests and configuration, gives the verdict
`timescale 1ns / 1ps
module flow_payload_reassembler_crc32c_tb;
  import fpr_pkg::*;

  localparam int GEN_FLOWS = 6;
  localparam int GEN_MAX = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           errors, awaited;
  int                    send_idle = 19;
  int                    recv_idle = 49;
  int                    stall_left = 0;

  bit          g_on[GEN_FLOWS];
  logic [15:0] g_src[GEN_FLOWS], g_dst[GEN_FLOWS], g_tag[GEN_FLOWS], g_seq[GEN_FLOWS];
  logic [1:0]  g_sub[GEN_FLOWS];
  logic [7:0]  g_pay[GEN_FLOWS][GEN_MAX];
  int          g_len[GEN_FLOWS];

  fpr_if #(.T(req_t)) req_ch ();
  fpr_if #(.T(rsp_t)) rsp_ch ();

  flow_payload_reassembler_crc32c dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  fpr_reassembly_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_data_i  (rsp_ch.data),
    .errors_o    (errors),
    .awaited_o   (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("flow_payload_reassembler_crc32c regression: fail");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off in the third phase
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input req_t r);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic void fill_flow(int s, int size);
    g_src[s] = pick16();
    g_dst[s] = pick16();
    g_tag[s] = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
    g_sub[s] = 2'($urandom_range(3));
    g_seq[s] = 16'd1;
    g_len[s] = size;
    for (int b = 0; b < size; b++) g_pay[s][b] = 8'($urandom);
    g_on[s] = 1'b1;
  endfunction

  function automatic req_t keyed(int s, req_e t);
    req_t r;
    r = '0;
    r.req_type = t;
    r.source = g_src[s];
    r.destination = g_dst[s];
    r.tag = g_tag[s];
    r.subflow = g_sub[s];
    return r;
  endfunction

  function automatic req_t decl_req(int s, bit bad_crc);
    req_t        r;
    logic [31:0] c;
    int          size;
    size = g_len[s];
    c = 32'hFFFF_FFFF;
    for (int b = 0; b < size; b++) c = crc_byte(c, g_pay[s][b]);
    r = keyed(s, REQ_DECL);
    r.seq_or_count = 16'((size + 15) / 16);
    r.data_lo = {32'($urandom) | 32'h1, ~c ^ {31'd0, bad_crc}};
    r.data_hi = 64'(size) * 64'd8;
    r.payload_bits = r.data_hi;
    return r;
  endfunction

  function automatic req_t frag_req(int s);
    req_t r;
    int   off, len;
    off = (int'(g_seq[s]) - 1) * 16;
    len = g_len[s] - off;
    if (len > 16) len = 16;
    r = keyed(s, REQ_DATA);
    r.seq_or_count = g_seq[s];
    r.frag_len = 5'(len);
    r.tail = (off + len == g_len[s]);
    for (int b = 0; b < len; b++) begin
      if (b < 8) r.data_lo[8*b +: 8] = g_pay[s][off + b];
      else r.data_hi[8*(b-8) +: 8] = g_pay[s][off + b];
    end
    return r;
  endfunction

  task automatic next_frag(int s);
    req_t r;
    r = frag_req(s);
    case ($urandom_range(15))
      0: r.seq_or_count = r.seq_or_count + 16'($urandom_range(1, 3));
      1: r.tail = ~r.tail;
      2: r.frag_len = 5'($urandom);
      3: r.data_hi[63] = 1'b1;
      4: r.seq_or_count = 16'd0;
      default: begin
        g_seq[s]++;
        if (r.tail) g_on[s] = 1'b0;
      end
    endcase
    send(r);
  endtask

  task automatic noise();
    req_t r;
    r.req_type = req_e'($urandom_range(3));
    r.source = pick16();
    r.destination = pick16();
    r.tag = pick16();
    r.subflow = 2'($urandom);
    r.seq_or_count = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(2));
    r.tail = 1'($urandom);
    r.frag_len = 5'($urandom);
    r.data_lo = {$urandom, $urandom};
    r.data_hi = {$urandom, $urandom};
    r.payload_bits = ($urandom_range(1) == 0) ? r.data_hi : 64'($urandom_range(64)) << 3;
    if ($urandom_range(3) == 0) r.data_hi = r.payload_bits;
    send(r);
  endtask

  task automatic random_traffic(int n);
    int p, s;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      s = $urandom_range(GEN_FLOWS - 1);
      if (p < 14 && !g_on[s]) begin
        fill_flow(s, ($urandom_range(19) == 0) ? $urandom_range(65, GEN_MAX)
                                                : $urandom_range(1, 64));
        send(decl_req(s, $urandom_range(7) == 0));
      end else if (p < 82 && g_on[s]) next_frag(s);
      else if (p < 86 && g_on[s]) begin
        g_on[s] = 1'b0;
        send(keyed(s, REQ_ABORT));
      end else noise();
    end
  endtask

  task automatic directed();
    req_t r;
    fill_flow(0, 20);
    g_tag[0] = 16'h0001;
    r = decl_req(0, 1'b0);
    r.tag = 16'd0;                                       send(r);
    r = decl_req(0, 1'b0); r.payload_bits = 64'd0;       send(r);
    r = decl_req(0, 1'b0); r.payload_bits = 64'd161;
    r.data_hi = 64'd161;                                 send(r);
    r = decl_req(0, 1'b0); r.data_hi = 64'd168;          send(r);
    r = decl_req(0, 1'b0); r.data_lo[63:32] = 32'd0;     send(r);
    r = decl_req(0, 1'b0); r.seq_or_count = 16'd3;       send(r);
    r = decl_req(0, 1'b0); r.payload_bits = ~64'd7;
    r.data_hi = r.payload_bits; r.seq_or_count = 16'hFFFF; send(r);
    send(decl_req(0, 1'b0));
    send(decl_req(0, 1'b0));
    r = frag_req(0); r.seq_or_count = 16'd0;             send(r);
    r = frag_req(0); r.tag = 16'd0;                      send(r);
    r = frag_req(0); r.frag_len = 5'd0; r.tail = 1'b1;   send(r);
    r = frag_req(0); r.frag_len = 5'd17;                 send(r);
    r = frag_req(0); r.frag_len = 5'd15;                 send(r);
    r = frag_req(0); r.frag_len = 5'd4; r.tail = 1'b1;
    r.data_hi[0] = 1'b1;                                 send(r);
    r = frag_req(0); r.tag = 16'd2;                      send(r);
    r = frag_req(0); r.seq_or_count = 16'd2;             send(r);
    r = frag_req(0); r.tail = 1'b1;                      send(r);
    send(frag_req(0));
    g_seq[0] = 16'd2;
    r = frag_req(0); r.frag_len = 5'd5;                  send(r);
    send(frag_req(0));
    send(keyed(0, REQ_ABORT));
    r = keyed(0, REQ_UNUSED);                            send(r);
    fill_flow(1, 16);
    send(decl_req(1, 1'b1));
    send(frag_req(1));
    fill_flow(1, 3);
    send(decl_req(1, 1'b0));
    send(keyed(1, REQ_ABORT));
    g_on[0] = 1'b0;
    g_on[1] = 1'b0;
  endtask

  initial begin
    logic [3:0]  limits[7];
    logic [23:0] budgets[7];
    limits = '{4'd8, 4'd1, 4'd2, 4'd15, 4'd0, 4'd8, 4'd4};
    budgets = '{24'd1048576, 24'hFFFFFF, 24'd40, 24'd1, 24'd0, 24'd300, 24'd2000};
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_FLOW_LIMIT;
    cfg_data <= '0;
    foreach (g_on[s]) g_on[s] = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 2) begin
        send_idle = 49;
        recv_idle = 19;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_FLOW_LIMIT, CFG_DATA_W'(limits[ph]));
      write_reg(CFG_BYTE_BUDGET, budgets[ph]);
      if (ph == 2) stall_left = 80;
      random_traffic(100);
      if (ph == 0) drain();
      random_traffic(100);
      drain();
    end
    if (errors == 0) $display("flow_payload_reassembler_crc32c regression: pass");
    else $display("flow_payload_reassembler_crc32c regression: fail");
    $finish;
  end
endmodule

// ===== flow_payload_reassembler_crc32c.f =====
rtl/fpr_pkg.sv
rtl/fpr_if.sv
rtl/fpr_cell.sv
rtl/fpr_ctrl.sv
rtl/flow_payload_reassembler_crc32c.sv
test/fpr_reassembly_checker.sv
test/flow_payload_reassembler_crc32c_tb.sv
